// ===== sv/bfsa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfsa_pkg
// Shared types and constants of the best-fit segment allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfsa_pkg;

   localparam int TAG_IN_W    = 8;
   localparam int SIZE_W      = 27;
   localparam int ALIGN_W     = 17;
   localparam int OFF_W       = 26;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;
   localparam int GRAIN_BITS  = 3;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_NO_FIT = 2'd1,
      STAT_NO_TAG = 2'd2,
      STAT_FULL   = 2'd3
   } status_type;

   typedef enum logic {
      REQ_ALLOC = 1'b0,
      REQ_FREE  = 1'b1
   } req_kind_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_RD0, S_LD0, S_RDN, S_LDN, S_TEST, S_MOD, S_AL, S_FIT, S_EVAL, S_ADV, S_DECIDE,
      S_FRD, S_FLD, S_FNRD, S_FNLD, S_FPLAN,
      S_MV_RD, S_MV_WR, S_WR_A, S_WR_B, S_WR_F, S_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== sv/bfsa_ram.sv =====
// ----------------------------------------------------------------------------
// bfsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

// ===== sv/bfsa_mod.sv =====
// ----------------------------------------------------------------------------
// bfsa_mod
// Bit-serial remainder unit: one dividend bit per cycle, restoring.
// ----------------------------------------------------------------------------
`default_nettype none

module bfsa_mod #(
   parameter int NW = 26,
   parameter int DW = 17
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] dividend,
   input  wire logic [DW-1:0] divisor,
   output logic               done,
   output logic      [DW-1:0] remainder
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [NW-1:0] num_ff, num_in;
   logic [DW-1:0] den_ff, den_in;
   logic [DW-1:0] rem_ff, rem_in;
   logic [DW:0]   trial;

   assign trial = {rem_ff, num_ff[NW-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(NW);
         num_in  = dividend;
         den_in  = divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[NW-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DW'(trial - {1'b0, den_ff});
         end else begin
            rem_in = DW'(trial);
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ===== sv/best_fit_segment_allocator_top.sv =====
// ----------------------------------------------------------------------------
// best_fit_segment_allocator_top
// Best-fit heap allocator over an ordered segment table, with coalescing free.
// ----------------------------------------------------------------------------
// Allocate: scans all F free and U used segments, running the remainder unit on
//   each free one, then moves M entries up and writes the new segment, plus a free
//   tail if one is left. No fit or table full: the scan only, no moves or writes.
// Free: scans up to the tagged segment at position P, then moves M entries down;
//   unknown tag scans all N. The bit-serial remainder unit sets the allocate pace.
// One item at a time; the next request can be accepted in the cycle the result shows;
// reset is synchronous, after reset INIT writes table entry 0, then idle.
`default_nettype none

module best_fit_segment_allocator_top #(
   parameter int              MAX_SEGMENTS = 64,
   parameter longint unsigned HEAP_BYTES   = 67108864,
   parameter int              TAG_BITS     = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // block_tag[7:0], request_size[34:8], align[51:35]
   input  wire logic [bfsa_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // req_type[0]
   input  wire logic                                req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // block_offset[25:0]
   output logic      [bfsa_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // status[1:0]
   output logic      [1:0]                          rsp_tuser
);

   import bfsa_pkg::*;

   localparam int IW  = $clog2(MAX_SEGMENTS);
   localparam int CNW = $clog2(MAX_SEGMENTS + 1);
   localparam int SW  = $clog2(HEAP_BYTES);
   localparam int XW  = ((SW > 28) ? SW : 28) + 2;
   localparam int TB  = TAG_BITS;
   localparam int EW  = SW + 1 + TB;
   localparam logic [XW-1:0] HEAP_X = XW'(HEAP_BYTES);

   state_type state_ff, state_in;

   // table RAM word: {start, free, owner}
   logic          wr_en;
   logic [IW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;
   logic [SW-1:0] rd_start;
   logic          rd_free;
   logic [TB-1:0] rd_owner;

   assign rd_owner = rd_data[TB-1:0];
   assign rd_free  = rd_data[TB];
   assign rd_start = rd_data[EW-1:TB+1];

   logic           mod_start, mod_done;
   logic [ALIGN_W-1:0] mod_rem;

   req_kind_type       kind_ff, kind_in;
   logic [TB-1:0]      tag_ff, tag_in;
   logic [SIZE_W:0]    size_ff, size_in;
   logic [ALIGN_W-1:0] a_ff, a_in;
   logic [CNW-1:0]     count_ff, count_in;
   logic [CNW-1:0]     idx_ff, idx_in;
   logic [SW-1:0]      cur_start_ff, cur_start_in;
   logic               cur_free_ff, cur_free_in;
   logic [SW-1:0]      nxt_start_ff, nxt_start_in;
   logic               nxt_free_ff, nxt_free_in;
   logic [XW-1:0]      end_ff, end_in;
   logic [XW-1:0]      al_ff, al_in;
   logic [XW-1:0]      d_ff, d_in;
   logic               ok_ff, ok_in;
   logic               found_ff, found_in;
   logic [CNW-1:0]     best_ff, best_in;
   logic [XW-1:0]      best_left_ff, best_left_in;
   logic [XW-1:0]      best_al_ff, best_al_in;
   logic               best_gap_ff, best_gap_in;
   logic               below_free_ff, below_free_in;
   logic               next_free_ff, next_free_in;
   logic               up_ff, up_in;
   logic [1:0]         k_ff, k_in;
   logic [CNW-1:0]     mv_ff, mv_in;
   logic [CNW-1:0]     lo_ff, lo_in;
   logic [CNW-1:0]     hi_ff, hi_in;
   status_type         res_status_ff, res_status_in;
   logic [OFF_W-1:0]   res_off_ff, res_off_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]   rsp_off_ff, rsp_off_in;

   logic               req_accept;
   logic [CNW-1:0]     idx_nx, ua;
   logic               has_next, mv_cont, fit, tail, full, out_free;
   logic [XW-1:0]      left;
   logic [1:0]         need;
   logic [SIZE_W:0]    size_round;

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign idx_nx     = idx_ff + CNW'(1);
   assign has_next   = idx_nx < count_ff;
   assign mv_cont    = up_ff ? (mv_ff >= lo_ff) : (mv_ff < hi_ff);
   assign fit        = ok_ff && (d_ff >= XW'(size_ff));
   assign left       = d_ff - XW'(size_ff);
   assign tail       = (best_left_ff != '0);
   assign need       = {1'b0, best_gap_ff} + {1'b0, tail};
   assign full       = ({1'b0, count_ff} + (CNW+1)'(need)) > (CNW+1)'(MAX_SEGMENTS);
   assign ua         = best_ff + CNW'(best_gap_ff);
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign size_round = ({1'b0, req_tdata[34:8]} + (SIZE_W+1)'(7)) &
                       ~(SIZE_W+1)'(7);

   bfsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bfsa_mod #(.NW(SW), .DW(ALIGN_W)) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (cur_start_ff),
      .divisor   (a_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT:   state_in = S_IDLE;
         S_IDLE: begin
            if (req_accept) begin
               state_in = (req_tuser == REQ_FREE) ? S_FRD : S_RD0;
            end
         end
         S_RD0:    state_in = S_LD0;
         S_LD0:    state_in = S_RDN;
         S_RDN:    state_in = has_next ? S_LDN : S_TEST;
         S_LDN:    state_in = S_TEST;
         S_TEST:   state_in = cur_free_ff ? S_MOD : S_ADV;
         S_MOD:    state_in = mod_done ? S_AL : S_MOD;
         S_AL:     state_in = S_FIT;
         S_FIT:    state_in = S_EVAL;
         S_EVAL:   state_in = S_ADV;
         S_ADV:    state_in = has_next ? S_RDN : S_DECIDE;
         S_DECIDE: state_in = (!found_ff || full) ? S_DONE : S_MV_RD;
         S_FRD:    state_in = (idx_ff < count_ff) ? S_FLD : S_DONE;
         S_FLD: begin
            if (!rd_free && rd_owner == tag_ff) begin
               state_in = S_FNRD;
            end else begin
               state_in = S_FRD;
            end
         end
         S_FNRD:   state_in = has_next ? S_FNLD : S_FPLAN;
         S_FNLD:   state_in = S_FPLAN;
         S_FPLAN:  state_in = S_MV_RD;
         S_MV_RD: begin
            if (mv_cont) begin
               state_in = S_MV_WR;
            end else if (kind_ff == REQ_ALLOC) begin
               state_in = S_WR_A;
            end else begin
               state_in = below_free_ff ? S_DONE : S_WR_F;
            end
         end
         S_MV_WR:  state_in = S_MV_RD;
         S_WR_A:   state_in = tail ? S_WR_B : S_DONE;
         S_WR_B:   state_in = S_DONE;
         S_WR_F:   state_in = S_DONE;
         S_DONE:   state_in = out_free ? S_IDLE : S_DONE;
         default:  state_in = S_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_addr       = '0;
      mod_start     = 1'b0;
      kind_in       = kind_ff;
      tag_in        = tag_ff;
      size_in       = size_ff;
      a_in          = a_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      cur_start_in  = cur_start_ff;
      cur_free_in   = cur_free_ff;
      nxt_start_in  = nxt_start_ff;
      nxt_free_in   = nxt_free_ff;
      end_in        = end_ff;
      al_in         = al_ff;
      d_in          = d_ff;
      ok_in         = ok_ff;
      found_in      = found_ff;
      best_in       = best_ff;
      best_left_in  = best_left_ff;
      best_al_in    = best_al_ff;
      best_gap_in   = best_gap_ff;
      below_free_in = below_free_ff;
      next_free_in  = next_free_ff;
      up_in         = up_ff;
      k_in          = k_ff;
      mv_in         = mv_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      res_status_in = res_status_ff;
      res_off_in    = res_off_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_off_in    = rsp_off_ff;
      case (state_ff)
         S_INIT: begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = {SW'(0), 1'b1, TB'(0)};
         end
         S_IDLE: begin
            if (req_accept) begin
               kind_in       = req_kind_type'(req_tuser);
               tag_in        = TB'(req_tdata[7:0]);
               size_in       = (size_round == '0) ? (SIZE_W+1)'(1 << GRAIN_BITS) : size_round;
               a_in          = (req_tdata[51:35] == '0) ? ALIGN_W'(1) : req_tdata[51:35];
               idx_in        = '0;
               found_in      = 1'b0;
               below_free_in = 1'b0;
               next_free_in  = 1'b0;
            end
         end
         S_RD0:   rd_addr = '0;
         S_LD0: begin
            cur_start_in = rd_start;
            cur_free_in  = rd_free;
         end
         S_RDN: begin
            rd_addr = idx_nx[IW-1:0];
            if (!has_next) begin
               end_in = HEAP_X;
            end
         end
         S_LDN: begin
            nxt_start_in = rd_start;
            nxt_free_in  = rd_free;
            end_in       = XW'(rd_start);
         end
         S_TEST:  mod_start = cur_free_ff;
         S_AL: begin
            al_in = XW'(cur_start_ff) +
                    ((mod_rem != '0) ? (XW'(a_ff) - XW'(mod_rem)) : XW'(0));
         end
         S_FIT: begin
            ok_in = al_ff <= end_ff;
            d_in  = end_ff - al_ff;
         end
         S_EVAL: begin
            if (fit && (!found_ff || left < best_left_ff)) begin
               found_in     = 1'b1;
               best_in      = idx_ff;
               best_left_in = left;
               best_al_in   = al_ff;
               best_gap_in  = al_ff != XW'(cur_start_ff);
            end
         end
         S_ADV: begin
            if (has_next) begin
               cur_start_in = nxt_start_ff;
               cur_free_in  = nxt_free_ff;
               idx_in       = idx_nx;
            end
         end
         S_DECIDE: begin
            res_off_in = '0;
            if (!found_ff) begin
               res_status_in = STAT_NO_FIT;
            end else if (full) begin
               res_status_in = STAT_FULL;
            end else begin
               res_status_in = STAT_OK;
               res_off_in    = OFF_W'(best_al_ff);
               up_in         = 1'b1;
               k_in          = need;
               mv_in         = count_ff - CNW'(1);
               lo_in         = best_ff + CNW'(1);
               count_in      = count_ff + CNW'(need);
            end
         end
         S_FRD: begin
            rd_addr = idx_ff[IW-1:0];
            if (idx_ff >= count_ff) begin
               res_status_in = STAT_NO_TAG;
               res_off_in    = '0;
            end
         end
         S_FLD: begin
            if (!rd_free && rd_owner == tag_ff) begin
               cur_start_in  = rd_start;
               res_status_in = STAT_OK;
               res_off_in    = OFF_W'(rd_start);
            end else begin
               below_free_in = rd_free;
               idx_in        = idx_nx;
            end
         end
         S_FNRD:  rd_addr = idx_nx[IW-1:0];
         S_FNLD:  next_free_in = rd_free;
         S_FPLAN: begin
            up_in    = 1'b0;
            k_in     = {1'b0, below_free_ff} + {1'b0, next_free_ff};
            mv_in    = idx_nx + CNW'(next_free_ff);
            hi_in    = count_ff;
            count_in = count_ff - CNW'({1'b0, below_free_ff} + {1'b0, next_free_ff});
         end
         S_MV_RD: rd_addr = mv_ff[IW-1:0];
         S_MV_WR: begin
            // inserts move entries up from the top, erases move them down from the bottom
            wr_en   = 1'b1;
            wr_data = rd_data;
            if (up_ff) begin
               wr_addr = IW'(mv_ff + CNW'(k_ff));
               mv_in   = mv_ff - CNW'(1);
            end else begin
               wr_addr = IW'(mv_ff - CNW'(k_ff));
               mv_in   = mv_ff + CNW'(1);
            end
         end
         S_WR_A: begin
            wr_en   = 1'b1;
            wr_addr = ua[IW-1:0];
            wr_data = {SW'(best_al_ff), 1'b0, tag_ff};
         end
         S_WR_B: begin
            wr_en   = 1'b1;
            wr_addr = IW'(ua + CNW'(1));
            wr_data = {SW'(best_al_ff + XW'(size_ff)), 1'b1, TB'(0)};
         end
         S_WR_F: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[IW-1:0];
            wr_data = {cur_start_ff, 1'b1, TB'(0)};
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_off_in    = res_off_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         count_ff     <= CNW'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      tag_ff        <= tag_in;
      size_ff       <= size_in;
      a_ff          <= a_in;
      idx_ff        <= idx_in;
      cur_start_ff  <= cur_start_in;
      cur_free_ff   <= cur_free_in;
      nxt_start_ff  <= nxt_start_in;
      nxt_free_ff   <= nxt_free_in;
      end_ff        <= end_in;
      al_ff         <= al_in;
      d_ff          <= d_in;
      ok_ff         <= ok_in;
      found_ff      <= found_in;
      best_ff       <= best_in;
      best_left_ff  <= best_left_in;
      best_al_ff    <= best_al_in;
      best_gap_ff   <= best_gap_in;
      below_free_ff <= below_free_in;
      next_free_ff  <= next_free_in;
      up_ff         <= up_in;
      k_ff          <= k_in;
      mv_ff         <= mv_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_status_ff <= res_status_in;
      res_off_ff    <= res_off_in;
      rsp_status_ff <= rsp_status_in;
      rsp_off_ff    <= rsp_off_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_TDATA_W'(rsp_off_ff);
   assign rsp_tuser  = rsp_status_ff;

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (count_ff != '0) && (count_ff <= CNW'(MAX_SEGMENTS)))
      else $error("segment count out of range");

   a_err_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff != STAT_OK) |-> (rsp_off_ff == '0))
      else $error("error result with nonzero offset");

   a_mod_phase: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_MOD))
      else $error("remainder finished outside the fit scan");
`endif

endmodule

`default_nettype wire
